@@ rtl/core/ppp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ppp_pkg;

  // Fixed-point format and field widths.
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned VP_REG_W      = 13;
  localparam int unsigned COEF_IDX_W    = 4;
  localparam int unsigned COEF_NUM      = 16;

  // Viewport registers after reset.
  localparam logic [VP_REG_W-1:0] VP_RESET = 13'd1024;

  // Configuration register indexes.
  localparam logic CFG_VP_WIDTH  = 1'b0;
  localparam logic CFG_VP_HEIGHT = 1'b1;

  // Item modes.
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_PROJECT = 1'b1;

  // One input item.
  typedef struct packed {
    logic                         mode;
    logic [COEF_IDX_W-1:0]        coef_index;
    logic signed [COORD_W-1:0]    coef_value;
    logic signed [COORD_W-1:0]    point_x;
    logic signed [COORD_W-1:0]    point_y;
    logic signed [COORD_W-1:0]    point_z;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [COORD_W-1:0]    screen_x;
    logic signed [COORD_W-1:0]    screen_y;
    logic                         in_view;
  } out_item_t;

  // Control from the sequencer to the transform datapath.
  typedef struct packed {
    logic                         start;
    logic                         wr_en;
    logic [COEF_IDX_W-1:0]        wr_idx;
    logic [COORD_W-1:0]           wr_data;
  } xf_ctrl_t;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XFORM,
    ST_TEST,
    ST_PREP,
    ST_DIV
  } pp_state_e;

endpackage

`default_nettype wire

@@ rtl/core/perspective_point_projector_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Perspective point projector.
// Items enter on item_i when start is high and busy is low. A load item
// (mode 0) writes one matrix coefficient in that cycle and gives no result;
// busy stays low, so loads may follow every cycle. A project item (mode 1)
// runs M*(x,y,z,1), tests the clip vector against the frustum and maps it
// to the viewport; busy stays high until the result is out.
// A project item reads the sixteen coefficients through the shared
// multiply-accumulate, then passes the test and operand setup, then the
// serial divider when the point is inside, and leaves through one output
// register. Busy falls as the result strobe rises, for a point inside as
// for one outside.
// Each result is shown for exactly one cycle with result_valid_o; the
// receiver cannot hold it off. Viewport registers are written through
// cfg_we_i/cfg_idx_i/cfg_data_i; the user must do so only while idle,
// which the block itself does not enforce. Reset sets both to 1024 and
// leaves the matrix unwritten; it must be loaded before projecting.
module perspective_point_projector_unit #(
  parameter int unsigned FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire ppp_pkg::in_item_t                item_i,
  output logic                                  result_valid_o,
  output ppp_pkg::out_item_t                    result_o,
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_idx_i,
  input  wire logic [ppp_pkg::VP_REG_W-1:0]     cfg_data_i
);

  localparam int unsigned CLIP_W = 67 - FRAC_BITS;
  localparam int unsigned D_W    = CLIP_W + 1;
  localparam logic [ppp_pkg::COORD_W-1:0] MINUS_ONE =
    ~((ppp_pkg::COORD_W'(1) << FRAC_BITS) - ppp_pkg::COORD_W'(1));

  ppp_pkg::pp_state_e                 state_q, state_d;
  logic [ppp_pkg::VP_REG_W-1:0]       vp_w_q;
  logic [ppp_pkg::VP_REG_W-1:0]       vp_h_q;
  logic signed [ppp_pkg::COORD_W-1:0] px_q, py_q, pz_q;
  logic                               accept;
  ppp_pkg::xf_ctrl_t                  xf_ctrl;
  logic                               xf_done;
  logic signed [CLIP_W-1:0]           clip [4];
  logic                               inside_q, inside_d;
  logic [D_W-1:0]                     nx_q, nx_d;
  logic [D_W-1:0]                     ny_q, ny_d;
  logic [D_W-1:0]                     den_q, den_d;
  logic                               div_start;
  logic                               divx_done, divy_done;
  logic [ppp_pkg::COORD_W-1:0]        qx, qy;
  logic                               res_vld_q, res_vld_d;
  ppp_pkg::out_item_t                 res_q, res_d;

  assign accept = start && !busy;
  assign busy   = (state_q != ppp_pkg::ST_IDLE);

  // Viewport registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_w_q <= ppp_pkg::VP_RESET;
      vp_h_q <= ppp_pkg::VP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ppp_pkg::CFG_VP_WIDTH:  vp_w_q <= cfg_data_i;
        ppp_pkg::CFG_VP_HEIGHT: vp_h_q <= cfg_data_i;
        default:                vp_w_q <= vp_w_q;
      endcase
    end
  end

  // Point capture on an accepted project item.
  always_ff @(posedge clk_i) begin
    if (accept && (item_i.mode == ppp_pkg::MODE_PROJECT)) begin
      px_q <= item_i.point_x;
      py_q <= item_i.point_y;
      pz_q <= item_i.point_z;
    end
  end

  // Transform control: loads write straight into the matrix store.
  always_comb begin
    xf_ctrl.start   = accept && (item_i.mode == ppp_pkg::MODE_PROJECT);
    xf_ctrl.wr_en   = accept && (item_i.mode == ppp_pkg::MODE_LOAD);
    xf_ctrl.wr_idx  = item_i.coef_index;
    xf_ctrl.wr_data = item_i.coef_value;
  end

  ppp_xform #(
    .FRAC_BITS (FRAC_BITS),
    .CLIP_W    (CLIP_W)
  ) u_xform (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (xf_ctrl),
    .px_i   (px_q),
    .py_i   (py_q),
    .pz_i   (pz_q),
    .done_o (xf_done),
    .clip_o (clip)
  );

  // Frustum test and divider operands from the clip vector.
  always_comb begin
    logic [CLIP_W-1:0]      ax, ay, aw;
    logic signed [D_W-1:0]  sx, sy;
    logic                   z_pos, w_pos;
    ax    = clip[0][CLIP_W-1] ? -clip[0] : clip[0];
    ay    = clip[1][CLIP_W-1] ? -clip[1] : clip[1];
    aw    = clip[3][CLIP_W-1] ? -clip[3] : clip[3];
    sx    = D_W'(clip[0]) + D_W'(clip[3]);
    sy    = D_W'(clip[3]) - D_W'(clip[1]);
    z_pos = !clip[2][CLIP_W-1] && (clip[2] != '0);
    w_pos = !clip[3][CLIP_W-1] && (clip[3] != '0);
    inside_d = (clip[3] != '0) && (ax <= aw) && (ay <= aw)
            && ((clip[2] == '0) || (z_pos == w_pos));
    nx_d  = sx[D_W-1] ? -sx : sx;
    ny_d  = sy[D_W-1] ? -sy : sy;
    den_d = {aw, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ppp_pkg::ST_TEST) begin
      inside_q <= inside_d;
      nx_q     <= nx_d;
      ny_q     <= ny_d;
      den_q    <= den_d;
    end
  end

  ppp_div #(
    .FRAC_BITS (FRAC_BITS),
    .D_W       (D_W)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (nx_q),
    .d_i     (den_q),
    .scale_i (vp_w_q),
    .done_o  (divx_done),
    .q_o     (qx)
  );

  ppp_div #(
    .FRAC_BITS (FRAC_BITS),
    .D_W       (D_W)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (ny_q),
    .d_i     (den_q),
    .scale_i (vp_h_q),
    .done_o  (divy_done),
    .q_o     (qy)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ppp_pkg::ST_IDLE:  if (xf_ctrl.start) state_d = ppp_pkg::ST_XFORM;
      ppp_pkg::ST_XFORM: if (xf_done) state_d = ppp_pkg::ST_TEST;
      ppp_pkg::ST_TEST:  state_d = ppp_pkg::ST_PREP;
      ppp_pkg::ST_PREP:  state_d = inside_q ? ppp_pkg::ST_DIV : ppp_pkg::ST_IDLE;
      ppp_pkg::ST_DIV:   if (divx_done) state_d = ppp_pkg::ST_IDLE;
      default:           state_d = ppp_pkg::ST_IDLE;
    endcase
  end

  // Output logic: divider launch and the result item.
  always_comb begin
    div_start      = 1'b0;
    res_vld_d      = 1'b0;
    res_d.screen_x = MINUS_ONE;
    res_d.screen_y = MINUS_ONE;
    res_d.in_view  = 1'b0;
    case (state_q)
      ppp_pkg::ST_PREP: begin
        div_start = inside_q;
        res_vld_d = !inside_q;
      end
      ppp_pkg::ST_DIV: begin
        res_vld_d      = divx_done;
        res_d.screen_x = qx;
        res_d.screen_y = qy;
        res_d.in_view  = 1'b1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ppp_pkg::ST_IDLE;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld_d) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

`ifndef NO_ASSERTIONS
  // A result never lasts more than one cycle.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");
  // An outside point reports minus one on both axes.
  a_outside_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.in_view |->
      (result_o.screen_x == MINUS_ONE) && (result_o.screen_y == MINUS_ONE))
    else $error("outside result carries a screen position");
  // A load item never makes the block busy.
  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (item_i.mode == ppp_pkg::MODE_LOAD) |=> !busy)
    else $error("load item made the block busy");
  // Both divider lanes finish together.
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    divx_done == divy_done)
    else $error("divider lanes out of step");
`endif

endmodule

`default_nettype wire

@@ rtl/core/ppp_xform.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Matrix store and shared multiply-accumulate. One coefficient is read per
// cycle; a row's three products are summed exactly, then floored to the
// fixed-point grid and the translation term is added.
module ppp_xform #(
  parameter int unsigned FRAC_BITS = ppp_pkg::FRAC_BITS_DEF,
  parameter int unsigned CLIP_W    = 67 - FRAC_BITS
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire ppp_pkg::xf_ctrl_t                     ctrl_i,
  input  wire logic signed [ppp_pkg::COORD_W-1:0]    px_i,
  input  wire logic signed [ppp_pkg::COORD_W-1:0]    py_i,
  input  wire logic signed [ppp_pkg::COORD_W-1:0]    pz_i,
  output logic                                       done_o,
  output logic signed [CLIP_W-1:0]                   clip_o [4]
);

  localparam int unsigned ACC_W  = 66;
  localparam int unsigned PROD_W = 2 * ppp_pkg::COORD_W;

  logic [ppp_pkg::COORD_W-1:0]        mem [ppp_pkg::COEF_NUM];
  logic                               run_q;
  logic [ppp_pkg::COEF_IDX_W-1:0]     cnt_q;
  logic [ppp_pkg::COORD_W-1:0]        rd_data_q;
  logic                               a_vld_q;
  logic [ppp_pkg::COEF_IDX_W-1:0]     a_idx_q;
  logic                               b_vld_q;
  logic [ppp_pkg::COEF_IDX_W-1:0]     b_idx_q;
  logic signed [PROD_W-1:0]           prod_q;
  logic signed [ppp_pkg::COORD_W-1:0] bias_q;
  logic signed [ACC_W-1:0]            acc_q;
  logic signed [CLIP_W-1:0]           clip_q [4];
  logic                               done_q;
  logic signed [ppp_pkg::COORD_W-1:0] coord;
  logic signed [ACC_W-1:0]            prod_ext;
  logic signed [ACC_W-1:0]            acc_shr;

  // Read-address sequencer: sixteen coefficients, row by row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      cnt_q   <= '0;
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (ctrl_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '1) begin
          run_q <= 1'b0;
        end
      end
      a_vld_q <= run_q;
      b_vld_q <= a_vld_q;
      done_q  <= b_vld_q && (b_idx_q == '1);
    end
  end

  // Coefficient memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[ctrl_i.wr_idx] <= ctrl_i.wr_data;
    end
    rd_data_q <= mem[cnt_q];
    a_idx_q   <= cnt_q;
  end

  // Pick the point coordinate that matches the coefficient's column.
  always_comb begin
    case (a_idx_q[1:0])
      2'd0:    coord = px_i;
      2'd1:    coord = py_i;
      default: coord = pz_i;
    endcase
  end

  // Multiplier stage.
  always_ff @(posedge clk_i) begin
    prod_q  <= $signed(rd_data_q) * coord;
    bias_q  <= $signed(rd_data_q);
    b_idx_q <= a_idx_q;
  end

  assign prod_ext = ACC_W'(prod_q);
  assign acc_shr  = acc_q >>> FRAC_BITS;

  // Accumulate stage; the last column closes the row.
  always_ff @(posedge clk_i) begin
    if (b_vld_q) begin
      case (b_idx_q[1:0])
        2'd0:    acc_q <= prod_ext;
        2'd3:    clip_q[b_idx_q[3:2]] <= CLIP_W'(acc_shr) + CLIP_W'(bias_q);
        default: acc_q <= acc_q + prod_ext;
      endcase
    end
  end

  assign done_o = done_q;
  assign clip_o = clip_q;

`ifndef NO_ASSERTIONS
  // A pass never restarts while it is still reading coefficients.
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q && (cnt_q != '1) |-> !ctrl_i.start)
    else $error("transform restarted mid-pass");
  // Completion follows the last read through the read-port, multiplier and done registers.
  a_done_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q && (cnt_q == '1) && !ctrl_i.start |-> ##3 done_q)
    else $error("transform completion misplaced");
`endif

endmodule

`default_nettype wire

@@ rtl/core/ppp_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Serial scaled divider: q = floor(n * scale * 2^FRAC_BITS / d), n <= d.
// One quotient digit (0, 1 or 2) per cycle: the scale bits first, then
// the fraction bits. The result saturates to the largest signed word.
module ppp_div #(
  parameter int unsigned FRAC_BITS = ppp_pkg::FRAC_BITS_DEF,
  parameter int unsigned D_W       = 68 - FRAC_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [D_W-1:0]                    n_i,
  input  wire logic [D_W-1:0]                    d_i,
  input  wire logic [ppp_pkg::VP_REG_W-1:0]      scale_i,
  output logic                                   done_o,
  output logic [ppp_pkg::COORD_W-1:0]            q_o
);

  localparam int unsigned NSTEP = ppp_pkg::VP_REG_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NSTEP + 1);
  localparam int unsigned T_W   = D_W + 2;
  localparam int unsigned Q_W   = (NSTEP > ppp_pkg::COORD_W) ? NSTEP : ppp_pkg::COORD_W;

  logic                              busy_q;
  logic                              done_q;
  logic [CNT_W-1:0]                  cnt_q;
  logic [D_W-1:0]                    n_q;
  logic [D_W-1:0]                    d_q;
  logic [D_W-1:0]                    r_q;
  logic [D_W-1:0]                    r_d;
  logic [ppp_pkg::VP_REG_W-1:0]      sc_q;
  logic [Q_W-1:0]                    q_q;
  logic [Q_W-1:0]                    q_d;
  logic [T_W-1:0]                    t;
  logic [T_W-1:0]                    d1;
  logic [T_W-1:0]                    d2;
  logic [1:0]                        digit;

  // One radix-2 step with a digit set of {0, 1, 2}.
  always_comb begin
    t  = {1'b0, r_q, 1'b0} + (sc_q[ppp_pkg::VP_REG_W-1] ? T_W'(n_q) : '0);
    d1 = T_W'(d_q);
    d2 = T_W'({d_q, 1'b0});
    if (t >= d2) begin
      digit = 2'd2;
      r_d   = D_W'(t - d2);
    end else if (t >= d1) begin
      digit = 2'd1;
      r_d   = D_W'(t - d1);
    end else begin
      digit = 2'd0;
      r_d   = D_W'(t);
    end
    q_d = {q_q[Q_W-2:0], 1'b0} + Q_W'(digit);
  end

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NSTEP - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial-result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q  <= n_i;
      d_q  <= d_i;
      r_q  <= '0;
      q_q  <= '0;
      sc_q <= scale_i;
    end else if (busy_q) begin
      r_q  <= r_d;
      q_q  <= q_d;
      sc_q <= {sc_q[ppp_pkg::VP_REG_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign q_o    = (|q_q[Q_W-1:ppp_pkg::COORD_W-1]) ? {1'b0, {(ppp_pkg::COORD_W-1){1'b1}}}
                                                   : ppp_pkg::COORD_W'(q_q);

`ifndef NO_ASSERTIONS
  // The remainder always stays below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (d_q != '0) |-> (r_q < d_q))
    else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

@@ tb/tb_perspective_point_projector_unit.sv @@
`timescale 1ns / 1ps

module tb_perspective_point_projector_unit;
  import ppp_pkg::*;

  localparam int unsigned FRAC          = FRAC_BITS_DEF;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_ITEMS    = 40;
  localparam int unsigned DRAIN_CYCLES  = 60;
  localparam logic signed [COORD_W-1:0] ONE_Q     = 32'sd1 <<< FRAC;
  localparam logic signed [COORD_W-1:0] NEG_ONE_Q = -ONE_Q;
  localparam logic signed [COORD_W-1:0] HALF_Q    = ONE_Q >>> 1;

  // One entry of the stimulus list: an item or a viewport register write.
  typedef struct {
    bit                    is_cfg;
    in_item_t              item;
    logic                  cfg_idx;
    logic [VP_REG_W-1:0]   cfg_data;
  } stim_entry_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  start      = 1'b0;
  logic                  busy;
  in_item_t              item_i     = '0;
  logic                  result_valid_o;
  out_item_t             result_o;
  logic                  cfg_we_i   = 1'b0;
  logic                  cfg_idx_i  = 1'b0;
  logic [VP_REG_W-1:0]   cfg_data_i = '0;

  // Shadow copy of the block state used for prediction.
  logic signed [COORD_W-1:0] coef_shadow [COEF_NUM];
  logic [VP_REG_W-1:0]       vp_width_shadow  = VP_RESET;
  logic [VP_REG_W-1:0]       vp_height_shadow = VP_RESET;

  stim_entry_t stim_q [$];
  out_item_t   screen_expect_q [$];
  int unsigned err_cnt    = 0;
  int unsigned gap_cnt    = 0;
  int unsigned settle_cnt = 0;
  logic        took;
  logic        start_n;
  logic        cfg_we_n;

  perspective_point_projector_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < COEF_NUM; i++) begin
      coef_shadow[COEF_IDX_W'(i)] = '0;
    end
  end

  // One clip component: exact sum of three products, floored once, plus the offset.
  function automatic logic signed [63:0] clip_component(int unsigned row,
                                                        logic signed [31:0] px,
                                                        logic signed [31:0] py,
                                                        logic signed [31:0] pz);
    logic signed [127:0] c0, c1, c2, c3, v0, v1, v2, acc;
    c0 = coef_shadow[COEF_IDX_W'(row * 4)];
    c1 = coef_shadow[COEF_IDX_W'(row * 4 + 1)];
    c2 = coef_shadow[COEF_IDX_W'(row * 4 + 2)];
    c3 = coef_shadow[COEF_IDX_W'(row * 4 + 3)];
    v0 = px;
    v1 = py;
    v2 = pz;
    acc = c0 * v0 + c1 * v1 + c2 * v2;
    acc = (acc >>> FRAC) + c3;
    return acc[63:0];
  endfunction

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // floor(num * scale * 2^FRAC / den), saturated to the largest positive word.
  function automatic logic [31:0] viewport_scale(logic [63:0] num, logic [63:0] den,
                                                 logic [VP_REG_W-1:0] scale);
    logic [127:0] n, d, s, q;
    n = num;
    d = den;
    s = scale;
    q = ((n * s) << FRAC) / d;
    if (q > 128'h7FFF_FFFF) begin
      q = 128'h7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  // Expected screen result of one project item.
  function automatic out_item_t project_point(in_item_t it);
    logic signed [63:0] cx, cy, cz, cw;
    logic [63:0]        aw;
    logic               in_frustum;
    out_item_t          res;
    cx = clip_component(0, it.point_x, it.point_y, it.point_z);
    cy = clip_component(1, it.point_x, it.point_y, it.point_z);
    cz = clip_component(2, it.point_x, it.point_y, it.point_z);
    cw = clip_component(3, it.point_x, it.point_y, it.point_z);
    aw = mag64(cw);
    in_frustum = (cw != 0) && (mag64(cx) <= aw) && (mag64(cy) <= aw)
                 && ((cz == 0) || ((cz > 0) == (cw > 0)));
    if (in_frustum) begin
      res.screen_x = viewport_scale(mag64(cx + cw), aw << 1, vp_width_shadow);
      res.screen_y = viewport_scale(mag64(cw - cy), aw << 1, vp_height_shadow);
      res.in_view  = 1'b1;
    end else begin
      res.screen_x = NEG_ONE_Q;
      res.screen_y = NEG_ONE_Q;
      res.in_view  = 1'b0;
    end
    return res;
  endfunction

  task automatic flag_error(string msg);
    if (err_cnt < 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    err_cnt++;
  endtask

  // Driver: presents pending items and applies register writes while idle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      cfg_we_i <= 1'b0;
    end else begin
      took = start && !busy;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_VP_WIDTH) begin
          vp_width_shadow = cfg_data_i;
        end else begin
          vp_height_shadow = cfg_data_i;
        end
      end
      if (took) begin
        if (item_i.mode == MODE_PROJECT) begin
          screen_expect_q.push_back(project_point(item_i));
        end else begin
          coef_shadow[item_i.coef_index] = item_i.coef_value;
        end
      end
      cfg_we_n = 1'b0;
      start_n  = start && !took;
      if (!start_n) begin
        if (gap_cnt != 0) begin
          gap_cnt--;
        end else if (stim_q.size() != 0) begin
          if (stim_q[0].is_cfg) begin
            // Wait for the block to drain before touching the viewport.
            if (screen_expect_q.size() == 0 && !busy && !took) begin
              settle_cnt++;
            end else begin
              settle_cnt = 0;
            end
            if (settle_cnt > SETTLE_CYCLES) begin
              cfg_we_n = 1'b1;
              cfg_idx_i  <= stim_q[0].cfg_idx;
              cfg_data_i <= stim_q[0].cfg_data;
              void'(stim_q.pop_front());
              settle_cnt = 0;
            end
          end else begin
            item_i <= stim_q[0].item;
            start_n = 1'b1;
            void'(stim_q.pop_front());
            if (stim_q.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
              gap_cnt = $urandom_range(1, 14);
            end
          end
        end
      end
      start    <= start_n;
      cfg_we_i <= cfg_we_n;
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (screen_expect_q.size() == 0) begin
        flag_error($sformatf("unexpected result x=%h y=%h in_view=%b",
                             result_o.screen_x, result_o.screen_y, result_o.in_view));
      end else if (result_o.screen_x !== screen_expect_q[0].screen_x
                   || result_o.screen_y !== screen_expect_q[0].screen_y
                   || result_o.in_view !== screen_expect_q[0].in_view) begin
        flag_error($sformatf("expected x=%h y=%h in_view=%b, got x=%h y=%h in_view=%b",
                             screen_expect_q[0].screen_x, screen_expect_q[0].screen_y,
                             screen_expect_q[0].in_view, result_o.screen_x,
                             result_o.screen_y, result_o.in_view));
        void'(screen_expect_q.pop_front());
      end else begin
        void'(screen_expect_q.pop_front());
      end
    end
  end

  function automatic logic signed [31:0] rand_span(int unsigned span);
    return $signed(32'($urandom_range(0, 2 * span))) - $signed(32'(span));
  endfunction

  function automatic logic signed [31:0] rand_word();
    return $signed($urandom());
  endfunction

  task automatic push_item(in_item_t it);
    stim_entry_t e;
    e.is_cfg   = 1'b0;
    e.item     = it;
    e.cfg_idx  = 1'b0;
    e.cfg_data = '0;
    stim_q.push_back(e);
  endtask

  task automatic push_cfg(logic idx, logic [VP_REG_W-1:0] data);
    stim_entry_t e;
    e.is_cfg   = 1'b1;
    e.item     = '0;
    e.cfg_idx  = idx;
    e.cfg_data = data;
    stim_q.push_back(e);
  endtask

  // Coefficient load; the point fields carry random bits that must be ignored.
  task automatic push_load(int unsigned idx, logic signed [31:0] val);
    in_item_t it;
    it.mode       = MODE_LOAD;
    it.coef_index = idx[COEF_IDX_W-1:0];
    it.coef_value = val;
    it.point_x    = rand_word();
    it.point_y    = rand_word();
    it.point_z    = rand_word();
    push_item(it);
  endtask

  // Project item; the coefficient fields carry random bits that must be ignored.
  task automatic push_point(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz);
    in_item_t it;
    it.mode       = MODE_PROJECT;
    it.coef_index = COEF_IDX_W'($urandom());
    it.coef_value = rand_word();
    it.point_x    = px;
    it.point_y    = py;
    it.point_z    = pz;
    push_item(it);
  endtask

  // A coefficient of a camera-like matrix: w dominated by its offset, so
  // that many points land inside the frustum.
  function automatic logic signed [31:0] scene_coef(int unsigned idx);
    logic signed [31:0] w_mag;
    if (idx < 8) begin
      return rand_span(32768);
    end else if (idx < 12) begin
      return rand_span(65536);
    end else if (idx < 15) begin
      return rand_span(16384);
    end else begin
      w_mag = $signed(32'(98304 + $urandom_range(0, 163840)));
      return ($urandom_range(0, 1) == 1) ? -w_mag : w_mag;
    end
  endfunction

  // Load all sixteen coefficients, starting at a random index.
  task automatic push_scene(bit wild);
    int unsigned off;
    int unsigned idx;
    off = $urandom_range(0, COEF_NUM - 1);
    for (int k = 0; k < COEF_NUM; k++) begin
      idx = (k + off) % COEF_NUM;
      push_load(idx, wild ? rand_word() : scene_coef(idx));
    end
  endtask

  initial begin
    int unsigned  n_proj;
    in_item_t     noise;
    logic [159:0] noise_bits;

    // Directed part: identity matrix, frustum edges, zero and negative w.
    for (int i = 0; i < COEF_NUM; i++) begin
      push_load(i, (i % 5 == 0) ? ONE_Q : 32'sd0);
    end
    push_point(ONE_Q, -ONE_Q, 32'sd0);
    push_point(-ONE_Q, ONE_Q, HALF_Q);
    push_point(ONE_Q + 32'sd1, 32'sd0, 32'sd0);
    push_point(32'sd0, 32'sd0, -32'sd1);
    push_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    push_point(HALF_Q >>> 1, ONE_Q - (ONE_Q >>> 2), ONE_Q);
    push_load(15, 32'sd0);
    push_point(32'sd0, 32'sd0, 32'sd0);
    push_load(15, NEG_ONE_Q);
    push_point(HALF_Q, -HALF_Q, -HALF_Q);
    push_point(HALF_Q, HALF_Q, HALF_Q);
    push_load(0, 32'sh8000_0000);
    push_load(15, 32'sh7FFF_FFFF);
    push_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0);

    // Random part: phases of register settings, each with a fresh matrix.
    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: begin
          push_cfg(CFG_VP_WIDTH, 13'd1);
          push_cfg(CFG_VP_HEIGHT, 13'd4096);
        end
        1: begin
          push_cfg(CFG_VP_WIDTH, 13'd8191);
          push_cfg(CFG_VP_HEIGHT, 13'd0);
        end
        2: begin
          push_cfg(CFG_VP_WIDTH, 13'd0);
          push_cfg(CFG_VP_HEIGHT, 13'd8191);
        end
        3: begin
          push_cfg(CFG_VP_WIDTH, 13'd4096);
          push_cfg(CFG_VP_HEIGHT, 13'd1);
        end
        default: begin
          if ($urandom_range(0, 1) == 1) begin
            push_cfg(CFG_VP_WIDTH, VP_REG_W'($urandom_range(1, 4096)));
            push_cfg(CFG_VP_HEIGHT, VP_REG_W'($urandom_range(1, 4096)));
          end
        end
      endcase
      push_scene($urandom_range(0, 4) == 0);
      n_proj = $urandom_range(8, 16);
      for (int k = 0; k < n_proj; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          push_load($urandom_range(0, COEF_NUM - 1), scene_coef($urandom_range(0, 15)));
        end
        if ($urandom_range(0, 9) == 0) begin
          // Fully random item of either mode.
          noise_bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
          noise      = noise_bits[$bits(in_item_t)-1:0];
          push_item(noise);
        end
        if ($urandom_range(0, 4) == 0) begin
          push_point(rand_word(), rand_word(), rand_word());
        end else begin
          push_point(rand_span(65536), rand_span(65536), rand_span(65536));
        end
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all stimulus to be taken, then for the last results.
    while (stim_q.size() != 0 || start) begin
      @(posedge clk_i);
    end
    while (screen_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (screen_expect_q.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", screen_expect_q.size()));
    end
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/ppp_pkg.sv
rtl/core/ppp_xform.sv
rtl/core/ppp_div.sv
rtl/core/perspective_point_projector_unit.sv
tb/tb_perspective_point_projector_unit.sv
